// File: rtl/adpm_pkg.sv
// adpm_pkg: shared types and codes of the approximate dna pattern matcher
// no dependencies; imported by every rtl file of the block
package adpm_pkg;

  // widths fixed by the register and field definitions
  localparam int unsigned PAT_BITS   = 64;
  localparam int unsigned LEN_BITS   = 6;
  localparam int unsigned ERR_BITS   = 4;
  localparam int unsigned SYM_BITS   = 3;
  localparam int unsigned CIDX_BITS  = 2;
  // positions the pattern register can hold
  localparam int unsigned PAT_SLOTS  = PAT_BITS / 2;

  // configuration register indexes
  localparam logic [CIDX_BITS-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CIDX_BITS-1:0] CFG_LENGTH  = 2'd1;
  localparam logic [CIDX_BITS-1:0] CFG_ERRORS  = 2'd2;

  // reset values of the registers
  localparam logic [PAT_BITS-1:0] PATTERN_RST = '0;
  localparam logic [LEN_BITS-1:0] LENGTH_RST  = 6'd1;
  localparam logic [ERR_BITS-1:0] ERRORS_RST  = 4'd0;

  // configuration as seen by front and back
  typedef struct packed {
    logic [PAT_BITS-1:0] pattern_symbols;
    logic [LEN_BITS-1:0] pattern_length;
    logic [ERR_BITS-1:0] max_errors;
  } cfg_t;

  // request presence between queue and its neighbours
  typedef struct packed {
    logic valid;
  } hs_t;

endpackage

// File: rtl/adpm_front.sv
// adpm_front: accepts text symbols and classifies them into a match mask
// depends on adpm_pkg; feeds adpm_queue
module adpm_front #(
  parameter int unsigned ROW_W = 32
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [adpm_pkg::SYM_BITS-1:0] in_symbol,
  input  adpm_pkg::cfg_t                cfg,
  output adpm_pkg::hs_t                 push_hs_o,
  input  logic                          push_ready_i,
  output logic [ROW_W-1:0]              push_mask_o
);
  import adpm_pkg::*;

  // one bit per pattern position whose symbol equals the text symbol; codes 4..7 set no bit
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      push_mask_o[i] = !in_symbol[2] &&
                       (cfg.pattern_symbols[2*i +: 2] == in_symbol[1:0]);
    end
  end

  // request goes to the queue as soon as it arrives
  assign in_ready        = push_ready_i;
  assign push_hs_o.valid = in_valid;

endmodule

// File: rtl/adpm_queue.sv
// adpm_queue: two-entry queue of match masks between front and back
// depends on adpm_pkg
module adpm_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  adpm_pkg::hs_t    push_hs_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output adpm_pkg::hs_t    pop_hs_o,
  input  logic             pop_take_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import adpm_pkg::*;

  logic [WIDTH-1:0] entry_r [2];
  logic [1:0]       count_r, count_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             do_push, do_pop;

  assign push_ready_o   = (count_r != 2'd2);
  assign do_push        = push_hs_i.valid && push_ready_o;
  assign do_pop         = pop_take_i && (count_r != 2'd0);
  assign pop_hs_o.valid = (count_r != 2'd0);
  assign pop_data_o     = entry_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

// File: rtl/adpm_back.sv
// adpm_back: k-differences automaton rows, match decision and output register
// depends on adpm_pkg; drains adpm_queue
module adpm_back #(
  parameter int unsigned ROW_W = 32,
  parameter int unsigned NROWS = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  adpm_pkg::cfg_t   cfg,
  input  logic             cfg_write_i,
  input  adpm_pkg::hs_t    pop_hs_i,
  output logic             pop_take_o,
  input  logic [ROW_W-1:0] pop_mask_i,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_match_found
);
  import adpm_pkg::*;

  localparam int unsigned LEN_W = $clog2(ROW_W + 1);
  localparam int unsigned IDX_W = $clog2(ROW_W);
  localparam int unsigned KW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int unsigned CW    = 8;

  logic [ROW_W-1:0] rows_r   [NROWS];
  logic [ROW_W-1:0] rows_nxt [NROWS];
  logic [ROW_W-1:0] rows_rst [NROWS];
  logic             restart_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_match_r;
  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] top_idx;
  logic [KW-1:0]    k_eff;
  logic [ROW_W-1:0] len_mask;
  logic             always_hit;
  logic             step;
  logic [ROW_W-1:0] calc;

  // effective length, mask and error count
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (CW'(cfg.pattern_length) > CW'(ROW_W)) begin
      len_eff = LEN_W'(ROW_W);
    end else begin
      len_eff = LEN_W'(cfg.pattern_length);
    end
    for (int i = 0; i < ROW_W; i++) begin
      len_mask[i] = (CW'(i) < CW'(len_eff));
    end
    if (CW'(cfg.max_errors) > CW'(NROWS - 1)) begin
      k_eff = KW'(NROWS - 1);
    end else begin
      k_eff = KW'(cfg.max_errors);
    end
    always_hit = (CW'(cfg.max_errors) >= CW'(len_eff));
    top_idx    = IDX_W'(len_eff - LEN_W'(1));
  end

  // restart rows: row r holds r low bits within the pattern length
  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      for (int i = 0; i < ROW_W; i++) begin
        rows_rst[r][i] = (i < r) && len_mask[i];
      end
    end
  end

  // one text step through rows 0 to k_eff, row r fed by row r-1 old and new; higher rows hold
  always_comb begin
    calc        = '0;
    rows_nxt[0] = {rows_r[0][ROW_W-2:0], 1'b1} & pop_mask_i & len_mask;
    for (int r = 1; r < NROWS; r++) begin
      calc = ({rows_r[r][ROW_W-2:0], 1'b1} & pop_mask_i)
           | rows_r[r-1]
           | {rows_r[r-1][ROW_W-2:0], 1'b1}
           | {rows_nxt[r-1][ROW_W-2:0], 1'b1};
      if (CW'(r) <= CW'(k_eff)) begin
        rows_nxt[r] = calc & len_mask;
      end else begin
        rows_nxt[r] = rows_r[r];
      end
    end
  end

  // take a request when the output slot is free or being emptied and no restart is pending
  assign step          = pop_hs_i.valid && !restart_r && (!out_valid_r || out_ready);
  assign pop_take_o    = step;
  assign out_valid_nxt = step || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      restart_r   <= cfg_write_i;
      out_valid_r <= out_valid_nxt;
    end
  end

  // automaton rows
  always_ff @(posedge clk) begin
    if (restart_r) begin
      rows_r <= rows_rst;
    end else if (step) begin
      rows_r <= rows_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_match_r <= always_hit || rows_nxt[k_eff][top_idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_match_r;

endmodule

// File: rtl/approx_dna_pattern_matcher.sv
// approx_dna_pattern_matcher: top level with configuration registers
// depends on adpm_pkg, adpm_front, adpm_queue and adpm_back
//
// Takes one text symbol per request (0=A 1=C 2=T 3=G, 4..7 any other) and
// returns one flag per symbol: 1 when some substring ending at that symbol is
// within max_errors edits of the configured pattern. Throughput is one symbol
// per cycle while out_ready holds and no restart is pending; the back part
// advances automaton rows 0 to max_errors (at most MAX_ERRORS) in one step.
// A request is written into the two-entry queue, then passes through the
// row update into the output register. A configuration write to index 0, 1
// or 2, and reset, reloads the rows in the cycle after it; a request waiting in
// the queue is held for that cycle. The configuration port always accepts;
// index 3 is ignored but still restarts nothing.
module approx_dna_pattern_matcher #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned MAX_ERRORS  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [adpm_pkg::SYM_BITS-1:0]  in_symbol,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_match_found,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [adpm_pkg::CIDX_BITS-1:0] cfg_index,
  input  logic [adpm_pkg::PAT_BITS-1:0]  cfg_data
);
  import adpm_pkg::*;

  localparam int unsigned ROW_W = (MAX_PATTERN < PAT_SLOTS) ? MAX_PATTERN : PAT_SLOTS;
  localparam int unsigned NROWS = MAX_ERRORS + 1;

  cfg_t             cfg_r, cfg_nxt;
  logic             cfg_hit;
  hs_t              push_hs, pop_hs;
  logic             push_ready;
  logic             pop_take;
  logic [ROW_W-1:0] push_mask, pop_mask;

  // configuration register writes
  assign cfg_ready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    cfg_hit = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN: begin
          cfg_nxt.pattern_symbols = cfg_data;
          cfg_hit = 1'b1;
        end
        CFG_LENGTH: begin
          cfg_nxt.pattern_length = cfg_data[LEN_BITS-1:0];
          cfg_hit = 1'b1;
        end
        CFG_ERRORS: begin
          cfg_nxt.max_errors = cfg_data[ERR_BITS-1:0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_symbols <= PATTERN_RST;
      cfg_r.pattern_length  <= LENGTH_RST;
      cfg_r.max_errors      <= ERRORS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  adpm_front #(
    .ROW_W (ROW_W)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_symbol    (in_symbol),
    .cfg          (cfg_r),
    .push_hs_o    (push_hs),
    .push_ready_i (push_ready),
    .push_mask_o  (push_mask)
  );

  // queue between front and back
  adpm_queue #(
    .WIDTH (ROW_W)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_hs_i    (push_hs),
    .push_ready_o (push_ready),
    .push_data_i  (push_mask),
    .pop_hs_o     (pop_hs),
    .pop_take_i   (pop_take),
    .pop_data_o   (pop_mask)
  );

  // back: automaton update and result
  adpm_back #(
    .ROW_W (ROW_W),
    .NROWS (NROWS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cfg_write_i     (cfg_hit),
    .pop_hs_i        (pop_hs),
    .pop_take_o      (pop_take),
    .pop_mask_i      (pop_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_found (out_match_found)
  );

endmodule

// File: tb/sv/tb_approx_dna_pattern_matcher.sv
// tb_approx_dna_pattern_matcher: self-checking bench for the approximate dna pattern matcher
// depends on adpm_pkg and approx_dna_pattern_matcher; keeps its own model of the
// k-differences automaton and checks every match flag against it
module tb_approx_dna_pattern_matcher;
  import adpm_pkg::*;

  localparam int unsigned MAX_PAT      = 32;
  localparam int unsigned MAX_ERR      = 8;
  localparam int unsigned N_PHASES     = 20;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PRINT_LIMIT  = 40;
  // register index past the end of the list, writes to it are ignored
  localparam logic [CIDX_BITS-1:0] CFG_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [SYM_BITS-1:0]  in_symbol = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_match_found;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CIDX_BITS-1:0] cfg_index = '0;
  logic [PAT_BITS-1:0]  cfg_data  = '0;

  // shadow configuration and automaton rows
  logic [PAT_BITS-1:0]  m_pattern;
  logic [LEN_BITS-1:0]  m_length;
  logic [ERR_BITS-1:0]  m_errors;
  logic [31:0]          nfa_rows [0:MAX_ERR];

  logic [SYM_BITS-1:0]  symbol_q [$];
  logic                 expected_match_q [$];
  logic                 exp_match;
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count    = 0;
  int unsigned          idle_pct       = 12;
  int unsigned          in_gap         = 0;
  int unsigned          out_gap        = 0;

  approx_dna_pattern_matcher #(
    .MAX_PATTERN (MAX_PAT),
    .MAX_ERRORS  (MAX_ERR)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_found (out_match_found),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // pattern length actually in use
  function automatic int unsigned eff_len();
    int unsigned len;
    int unsigned cap;
    len = m_length;
    cap = (MAX_PAT < PAT_SLOTS) ? MAX_PAT : PAT_SLOTS;
    if (len == 0) len = 1;
    if (len > cap) len = cap;
    return len;
  endfunction

  function automatic logic [31:0] row_mask(input int unsigned n);
    if (n >= 32) return '1;
    return (32'd1 << n) - 32'd1;
  endfunction

  // rows go back to r leading prefix bits set
  function automatic void restart_rows();
    for (int unsigned r = 0; r <= MAX_ERR; r++)
      nfa_rows[r] = row_mask(r) & row_mask(eff_len());
  endfunction

  // advance the automaton by one text symbol and give the match flag
  function automatic logic step_automaton(input logic [SYM_BITS-1:0] sym);
    int unsigned len;
    int unsigned k;
    logic [31:0] lm;
    logic [31:0] pm;
    logic [31:0] prev_old;
    logic [31:0] prev_new;
    logic [31:0] cur_old;
    logic [31:0] cur_new;
    logic        hit_always;
    len        = eff_len();
    lm         = row_mask(len);
    k          = m_errors;
    hit_always = (k >= len);
    if (k > MAX_ERR) k = MAX_ERR;
    // positions equal to the symbol; other characters match nowhere
    pm = '0;
    if (sym < 3'd4) begin
      for (int unsigned i = 0; i < len; i++)
        if (m_pattern[2*i +: 2] == sym[1:0]) pm[i] = 1'b1;
    end
    prev_old    = nfa_rows[0];
    prev_new    = ((prev_old << 1) | 32'd1) & pm & lm;
    nfa_rows[0] = prev_new;
    for (int unsigned r = 1; r <= k; r++) begin
      cur_old = nfa_rows[r];
      cur_new = (((cur_old << 1) | 32'd1) & pm)
              | prev_old
              | ((prev_old << 1) | 32'd1)
              | ((prev_new << 1) | 32'd1);
      cur_new     = cur_new & lm;
      nfa_rows[r] = cur_new;
      prev_old    = cur_old;
      prev_new    = cur_new;
    end
    if (hit_always) return 1'b1;
    return nfa_rows[k][len-1];
  endfunction

  // one register write; the shadow copy follows at acceptance
  task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input logic [PAT_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PATTERN: begin
        m_pattern = val;
        restart_rows();
      end
      CFG_LENGTH: begin
        m_length = val[LEN_BITS-1:0];
        restart_rows();
      end
      CFG_ERRORS: begin
        m_errors = val[ERR_BITS-1:0];
        restart_rows();
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random bits above a narrow register value
  function automatic logic [PAT_BITS-1:0] junk_above(input logic [PAT_BITS-1:0] v,
                                                     input int unsigned w);
    logic [PAT_BITS-1:0] junk;
    junk = {$urandom(), $urandom()};
    return (junk << w) | v;
  endfunction

  function automatic logic [SYM_BITS-1:0] noise_symbol();
    if ($urandom_range(0, 7) == 0) return SYM_BITS'($urandom_range(4, 7));
    return SYM_BITS'($urandom_range(0, 3));
  endfunction

  // copy of the pattern with a few random edits, sometimes one too many
  task automatic push_pattern_copy();
    int unsigned len;
    int unsigned edits;
    int unsigned roll;
    logic [SYM_BITS-1:0] sym;
    len   = eff_len();
    edits = 0;
    for (int unsigned pos = 0; pos < len; pos++) begin
      sym  = {1'b0, m_pattern[2*pos +: 2]};
      roll = $urandom_range(0, 15);
      if (edits <= m_errors && roll == 0) begin
        symbol_q.push_back(noise_symbol());
        edits++;
      end else if (edits <= m_errors && roll == 1) begin
        edits++;
      end else if (edits <= m_errors && roll == 2) begin
        symbol_q.push_back(noise_symbol());
        symbol_q.push_back(sym);
        edits++;
      end else begin
        symbol_q.push_back(sym);
      end
    end
  endtask

  // mostly near copies of the pattern, the rest noise runs
  task automatic push_phase_text(input int unsigned n);
    int unsigned start;
    start = symbol_q.size();
    while (symbol_q.size() - start < n) begin
      if ($urandom_range(0, 9) < 6)
        push_pattern_copy();
      else
        repeat ($urandom_range(1, 8)) symbol_q.push_back(noise_symbol());
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (symbol_q.size() != 0 || in_valid || expected_match_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver: requests from the symbol queue with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_match_q.push_back(step_automaton(in_symbol));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (symbol_q.size() != 0 && idle_pct != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          in_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (symbol_q.size() != 0) begin
          in_valid  <= 1'b1;
          in_symbol <= symbol_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_match_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_match = expected_match_q.pop_front();
          if (out_match_found !== exp_match)
            report_mismatch($sformatf("match_found %b, expected %b",
                                      out_match_found, exp_match));
        end
      end
      if (out_gap != 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned len_val;
    int unsigned err_val;
    int unsigned sel;
    int unsigned cap_err;
    m_pattern = PATTERN_RST;
    m_length  = LENGTH_RST;
    m_errors  = ERRORS_RST;
    restart_rows();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, every symbol code including the other characters
    for (int unsigned s = 0; s < 8; s++) symbol_q.push_back(SYM_BITS'(s));
    wait_drained();

    // pattern A C T G with one error allowed: exact copy, then one substitution
    write_reg(CFG_PATTERN, junk_above(64'he4, 8));
    write_reg(CFG_LENGTH, junk_above(64'd4, LEN_BITS));
    write_reg(CFG_ERRORS, junk_above(64'd1, ERR_BITS));
    symbol_q = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd2, 3'd3};
    wait_drained();

    // ignored index, length zero taken as one, errors at the top of the field
    write_reg(CFG_UNUSED, {$urandom(), $urandom()});
    write_reg(CFG_LENGTH, junk_above(64'd0, LEN_BITS));
    write_reg(CFG_ERRORS, junk_above(64'd15, ERR_BITS));
    symbol_q = '{3'd5, 3'd0};
    wait_drained();

    // all-G pattern, oversized length cut to the register capacity, most errors
    write_reg(CFG_PATTERN, '1);
    write_reg(CFG_LENGTH, junk_above(64'd63, LEN_BITS));
    write_reg(CFG_ERRORS, junk_above(64'd8, ERR_BITS));
    repeat (7) symbol_q.push_back(3'd3);
    wait_drained();

    // random phases, each with its own setting
    for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
      if (phase >= N_PHASES - 3)
        idle_pct = 0;
      else
        idle_pct = ($urandom_range(0, 4) == 0) ? 0 : 12;

      if ($urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)
          write_reg(CFG_PATTERN, '0);
        else if (sel == 1)
          write_reg(CFG_PATTERN, '1);
        else
          write_reg(CFG_PATTERN, {$urandom(), $urandom()});
      end

      if ($urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, 9);
        case (sel)
          6:       len_val = 32;
          7:       len_val = $urandom_range(11, 31);
          8:       len_val = 0;
          9:       len_val = $urandom_range(33, 63);
          default: len_val = $urandom_range(1, 10);
        endcase
        write_reg(CFG_LENGTH, junk_above(64'(len_val), LEN_BITS));
      end

      if ($urandom_range(0, 4) != 0) begin
        cap_err = (eff_len() - 1 < MAX_ERR) ? eff_len() - 1 : MAX_ERR;
        sel     = $urandom_range(0, 7);
        case (sel)
          5:       err_val = MAX_ERR;
          6:       err_val = $urandom_range(9, 15);
          7:       err_val = $urandom_range(0, 15);
          default: err_val = $urandom_range(0, cap_err);
        endcase
        write_reg(CFG_ERRORS, junk_above(64'(err_val), ERR_BITS));
      end

      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_UNUSED, {$urandom(), $urandom()});

      push_phase_text(PHASE_ITEMS);
      wait_drained();
    end

    if (expected_match_q.size() != 0)
      report_mismatch("requests left without a result");
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
